// ----- rtl/kbdsc_pkg.sv -----
package kbdsc_pkg;

   // Ring geometry
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Word layout
   localparam int CODE_W      = 8;
   localparam int MOD_W       = 4;
   localparam int CHAR_W      = 7;
   localparam int RSP_FIELD_W = CODE_W + MOD_W + CHAR_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Commands carried in req_tuser
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Set-1 modifier make codes (low seven bits)
   localparam logic [6:0] KEY_LSHIFT = 7'h2a;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_LCTRL  = 7'h1d;
   localparam logic [6:0] KEY_LALT   = 7'h38;

   // Modifier nibble bits
   localparam logic [MOD_W-1:0] MOD_LSHIFT = 4'b0001;
   localparam logic [MOD_W-1:0] MOD_RSHIFT = 4'b0010;
   localparam logic [MOD_W-1:0] MOD_LCTRL  = 4'b0100;
   localparam logic [MOD_W-1:0] MOD_LALT   = 4'b1000;

   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } kbdsc_state_type;

   typedef struct packed {
      logic [MOD_W-1:0]  mods;
      logic [CHAR_W-1:0] ch;
   } kbdsc_dec_type;

   function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] idx);
      return (idx == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : idx + PTR_W'(1);
   endfunction

   // US layout, unshifted
   function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;  6'd4:  ch = 7'h33;  6'd5:  ch = 7'h34;
         6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;  6'd8:  ch = 7'h37;  6'd9:  ch = 7'h38;
         6'd10: ch = 7'h39;  6'd11: ch = 7'h30;  6'd12: ch = 7'h2d;  6'd13: ch = 7'h3d;
         6'd14: ch = 7'h08;  6'd15: ch = 7'h09;
         6'd16: ch = 7'h71;  6'd17: ch = 7'h77;  6'd18: ch = 7'h65;  6'd19: ch = 7'h72;
         6'd20: ch = 7'h74;  6'd21: ch = 7'h79;  6'd22: ch = 7'h75;  6'd23: ch = 7'h69;
         6'd24: ch = 7'h6f;  6'd25: ch = 7'h70;  6'd26: ch = 7'h5b;  6'd27: ch = 7'h5d;
         6'd28: ch = 7'h0a;  6'd30: ch = 7'h61;  6'd31: ch = 7'h73;
         6'd32: ch = 7'h64;  6'd33: ch = 7'h66;  6'd34: ch = 7'h67;  6'd35: ch = 7'h68;
         6'd36: ch = 7'h6a;  6'd37: ch = 7'h6b;  6'd38: ch = 7'h6c;  6'd39: ch = 7'h3b;
         6'd40: ch = 7'h27;  6'd41: ch = 7'h60;  6'd43: ch = 7'h5c;
         6'd44: ch = 7'h7a;  6'd45: ch = 7'h78;  6'd46: ch = 7'h63;  6'd47: ch = 7'h76;
         6'd48: ch = 7'h62;  6'd49: ch = 7'h6e;  6'd50: ch = 7'h6d;  6'd51: ch = 7'h2c;
         6'd52: ch = 7'h2e;  6'd53: ch = 7'h2f;  6'd57: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   // US layout, shift held
   function automatic logic [CHAR_W-1:0] shift_char(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;  6'd4:  ch = 7'h23;  6'd5:  ch = 7'h24;
         6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5e;  6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2a;
         6'd10: ch = 7'h28;  6'd11: ch = 7'h29;  6'd12: ch = 7'h5f;  6'd13: ch = 7'h2b;
         6'd14: ch = 7'h08;  6'd15: ch = 7'h09;
         6'd16: ch = 7'h51;  6'd17: ch = 7'h57;  6'd18: ch = 7'h45;  6'd19: ch = 7'h52;
         6'd20: ch = 7'h54;  6'd21: ch = 7'h59;  6'd22: ch = 7'h55;  6'd23: ch = 7'h49;
         6'd24: ch = 7'h4f;  6'd25: ch = 7'h50;  6'd26: ch = 7'h7b;  6'd27: ch = 7'h7d;
         6'd28: ch = 7'h0a;  6'd30: ch = 7'h41;  6'd31: ch = 7'h53;
         6'd32: ch = 7'h44;  6'd33: ch = 7'h46;  6'd34: ch = 7'h47;  6'd35: ch = 7'h48;
         6'd36: ch = 7'h4a;  6'd37: ch = 7'h4b;  6'd38: ch = 7'h4c;  6'd39: ch = 7'h3a;
         6'd40: ch = 7'h22;  6'd41: ch = 7'h7e;  6'd43: ch = 7'h7c;
         6'd44: ch = 7'h5a;  6'd45: ch = 7'h58;  6'd46: ch = 7'h43;  6'd47: ch = 7'h56;
         6'd48: ch = 7'h42;  6'd49: ch = 7'h4e;  6'd50: ch = 7'h4d;  6'd51: ch = 7'h3c;
         6'd52: ch = 7'h3e;  6'd53: ch = 7'h3f;  6'd57: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/kbdsc_ram.sv -----
module kbdsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/kbdsc_decode.sv -----
module kbdsc_decode
   import kbdsc_pkg::*;
(
   input  logic [CODE_W-1:0] code,
   input  logic [MOD_W-1:0]  mods_in,
   output kbdsc_dec_type     dec
);

   logic [MOD_W-1:0] mod_hit;
   logic             brk;

   assign brk = code[CODE_W-1];

   always_comb begin
      unique case (code[6:0])
         KEY_LSHIFT: mod_hit = MOD_LSHIFT;
         KEY_RSHIFT: mod_hit = MOD_RSHIFT;
         KEY_LCTRL:  mod_hit = MOD_LCTRL;
         KEY_LALT:   mod_hit = MOD_LALT;
         default:    mod_hit = '0;
      endcase

      dec.mods = mods_in;
      dec.ch   = '0;
      if (mod_hit != '0) begin
         // break releases the key, make presses it
         dec.mods = brk ? (mods_in & ~mod_hit) : (mods_in | mod_hit);
      end else if (code[7:6] == 2'b00) begin
         // make code inside the table
         if ((mods_in & (MOD_LSHIFT | MOD_RSHIFT)) != '0) begin
            dec.ch = shift_char(code[5:0]);
         end else begin
            dec.ch = plain_char(code[5:0]);
         end
      end
   end

endmodule

// ----- rtl/keyboard_scancode_queue_decoder_unit.sv -----
// Keyboard scancode queue and set-1 decoder. Each input word carries a command in
// req_tuser: a push stores the scancode in req_tdata into a ring memory of
// QUEUE_DEPTH bytes, and a read takes the oldest byte out and decodes it into
// a character using the US layout, while tracking left/right shift, left ctrl
// and left alt from their make and break codes. A push to a full queue is
// dropped and raises a sticky overflow flag that the next successful read
// reports and clears. A read of an empty queue returns a word with the empty
// flag in rsp_tuser and all data zero, leaving state untouched. A read first
// launches the registered read of the ring memory, then decodes into the output
// register; it holds in the decode state while the output register still
// waits for rsp_tready. The output register lets pushes be accepted while a
// result is pending. No clearing pass after reset: queue entries are only read
// after they are written.
module keyboard_scancode_queue_decoder_unit
   import kbdsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CODE_W-1:0]      req_tdata,  // [7:0] raw_code
   input  logic                   req_tuser,  // [0] cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] raw_code_out, [11:8] modifier_bits, [18:12] ascii_char,
   // [19] overflowed, [23:20] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser   // [0] queue_empty
);

   kbdsc_state_type        state_ff, state_in;
   logic [PTR_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [PTR_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [MOD_W-1:0]       mods_ff, mods_in;
   logic                   ovf_ff, ovf_in;
   logic                   empty_ff, empty_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tuser_ff, rsp_tuser_in;

   logic                   ram_we;
   logic                   ram_re;
   logic [CODE_W-1:0]      ram_rdata;
   logic                   out_free;
   kbdsc_dec_type          dec;

   kbdsc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   kbdsc_decode u_decode (
      .code    (ram_rdata),
      .mods_in (mods_ff),
      .dec     (dec)
   );

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         fill_ff       <= '0;
         mods_ff       <= '0;
         ovf_ff        <= 1'b0;
         empty_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         fill_ff       <= fill_in;
         mods_ff       <= mods_in;
         ovf_ff        <= ovf_in;
         empty_ff      <= empty_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      fill_in       = fill_ff;
      mods_in       = mods_ff;
      ovf_in        = ovf_ff;
      empty_in      = empty_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_PUSH) begin
                  if (fill_ff == CNT_W'(QUEUE_DEPTH)) begin
                     // full: drop the byte, remember the loss
                     ovf_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     wr_idx_in = next_index(wr_idx_ff);
                     fill_in   = fill_ff + CNT_W'(1);
                  end
               end else begin
                  // launch the ring read, decode next cycle
                  empty_in = (fill_ff == '0);
                  ram_re   = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // hold until the output register can take the word
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
               if (empty_ff) begin
                  rsp_tuser_in = 1'b1;
                  rsp_tdata_in = '0;
               end else begin
                  rsp_tuser_in = 1'b0;
                  rsp_tdata_in = {{RSP_PAD_W{1'b0}}, ovf_ff, dec.ch, dec.mods, ram_rdata};
                  mods_in      = dec.mods;
                  ovf_in       = 1'b0;
                  rd_idx_in    = next_index(rd_idx_ff);
                  fill_in      = fill_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- verif/keyboard_scancode_queue_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module keyboard_scancode_queue_decoder_unit_tb;
   import kbdsc_pkg::*;

   // Set-1 codes below this value index the US layout tables
   localparam int LAYOUT_KEYS = 64;
   localparam logic [CODE_W-1:0] BREAK_FLAG = 8'h80;
   localparam longint RUN_LIMIT_NS = 64'd10_000_000;

   // One decoded key word as it appears on the result side
   typedef struct packed {
      logic                 empty;
      logic [CODE_W-1:0]    code;
      logic [MOD_W-1:0]     mods;
      logic [CHAR_W-1:0]    ch;
      logic                 ovf;
      logic [RSP_PAD_W-1:0] pad;
   } key_word_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CODE_W-1:0]      req_tdata  = '0;   // [7:0] raw_code
   logic                   req_tuser  = CMD_PUSH; // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] raw_code_out, [11:8] modifier_bits, [18:12] ascii_char,
   // [19] overflowed, [23:20] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;  // [0] queue_empty

   // Mirror of the block: queued scancodes, held modifiers, sticky drop flag
   logic [CODE_W-1:0] ring_codes[$];
   logic [MOD_W-1:0]  mods_held = '0;
   logic              drop_flag = 1'b0;
   key_word_type      pending_keys[$];
   logic [CODE_W-1:0] phrase_codes[$];

   int  mismatches = 0;
   bit  tx_gaps = 1'b0;
   bit  rx_stalls = 1'b0;
   int  rx_hold = 0;

   // US layout, unshifted and shifted, indexed by make code
   logic [CHAR_W-1:0] us_plain [LAYOUT_KEYS] = '{
      'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2d, 'h3d, 'h08, 'h09,
      'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69,
      'h6f, 'h70, 'h5b, 'h5d, 'h0a, 'h00, 'h61, 'h73,
      'h64, 'h66, 'h67, 'h68, 'h6a, 'h6b, 'h6c, 'h3b,
      'h27, 'h60, 'h00, 'h5c, 'h7a, 'h78, 'h63, 'h76,
      'h62, 'h6e, 'h6d, 'h2c, 'h2e, 'h2f, 'h00, 'h00,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00
   };
   logic [CHAR_W-1:0] us_shift [LAYOUT_KEYS] = '{
      'h00, 'h00, 'h21, 'h40, 'h23, 'h24, 'h25, 'h5e,
      'h26, 'h2a, 'h28, 'h29, 'h5f, 'h2b, 'h08, 'h09,
      'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
      'h4f, 'h50, 'h7b, 'h7d, 'h0a, 'h00, 'h41, 'h53,
      'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h3a,
      'h22, 'h7e, 'h00, 'h7c, 'h5a, 'h58, 'h43, 'h56,
      'h42, 'h4e, 'h4d, 'h3c, 'h3e, 'h3f, 'h00, 'h00,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00
   };

   keyboard_scancode_queue_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case a word never shows up or a handshake hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   // Pause length: mostly none or short, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Modifier bit that a code's low seven bits select, zero for other keys
   function automatic logic [MOD_W-1:0] modifier_bit(input logic [6:0] key);
      case (key)
         KEY_LSHIFT: return MOD_LSHIFT;
         KEY_RSHIFT: return MOD_RSHIFT;
         KEY_LCTRL:  return MOD_LCTRL;
         KEY_LALT:   return MOD_LALT;
         default:    return '0;
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] pick_modifier_key();
      case ($urandom_range(0, 3))
         0:       return {1'b0, KEY_LSHIFT};
         1:       return {1'b0, KEY_RSHIFT};
         2:       return {1'b0, KEY_LCTRL};
         default: return {1'b0, KEY_LALT};
      endcase
   endfunction

   // Apply one accepted word to the mirror; a read queues the key word it yields
   task automatic track_key_word(input logic cmd, input logic [CODE_W-1:0] code);
      key_word_type      w;
      logic [CODE_W-1:0] taken;
      logic [MOD_W-1:0]  hit;
      w = '0;
      if (cmd == CMD_PUSH) begin
         // Drop on a full ring and remember it until the next real read
         if (ring_codes.size() >= QUEUE_DEPTH) drop_flag = 1'b1;
         else ring_codes.push_back(code);
         return;
      end
      if (ring_codes.size() == 0) begin
         // Empty read: flag only, state untouched
         w.empty = 1'b1;
         pending_keys.push_back(w);
         return;
      end
      taken = ring_codes.pop_front();
      hit = modifier_bit(taken[6:0]);
      if (hit != '0) begin
         if (taken[7]) mods_held = mods_held & ~hit;
         else mods_held = mods_held | hit;
      end else if (taken < CODE_W'(LAYOUT_KEYS)) begin
         // Make code inside the table; break codes and high codes give nothing
         if ((mods_held & (MOD_LSHIFT | MOD_RSHIFT)) != '0) w.ch = us_shift[taken[5:0]];
         else w.ch = us_plain[taken[5:0]];
      end
      w.code = taken;
      w.mods = mods_held;
      w.ovf = drop_flag;
      drop_flag = 1'b0;
      pending_keys.push_back(w);
   endtask

   // Present one word, hold it until the handshake, then update the mirror
   task automatic send_word(input logic cmd, input logic [CODE_W-1:0] code);
      int gap;
      gap = tx_gaps ? pick_pause() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      track_key_word(cmd, code);
   endtask

   // Stop sending and let every outstanding key word arrive
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_keys.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Next pushed code: mostly typed phrases, sometimes line noise
   task automatic next_typed_code(output logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] mod_key;
      logic [CODE_W-1:0] key;
      bit                with_mod;
      if (phrase_codes.size() == 0) begin
         if ($urandom_range(0, 99) < 85) begin
            with_mod = 1'($urandom_range(0, 1));
            mod_key = pick_modifier_key();
            if (with_mod) phrase_codes.push_back(mod_key);
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 9) == 0) key = CODE_W'($urandom_range(LAYOUT_KEYS, 127));
               else key = CODE_W'($urandom_range(0, LAYOUT_KEYS - 1));
               phrase_codes.push_back(key);
               if ($urandom_range(0, 1)) phrase_codes.push_back(key | BREAK_FLAG);
            end
            // Leave a modifier stuck down once in a while
            if (with_mod && $urandom_range(0, 3) != 0)
               phrase_codes.push_back(mod_key | BREAK_FLAG);
         end else begin
            repeat ($urandom_range(1, 4)) phrase_codes.push_back(CODE_W'($urandom_range(0, 255)));
         end
      end
      code = phrase_codes.pop_front();
   endtask

   // Result side: randomly stall, sometimes for long stretches
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_stalls && $urandom_range(0, 99) < 30) rx_hold = pick_pause();
      end
   end

   // Compare every accepted key word with the oldest expectation
   always @(posedge clock) begin
      key_word_type got;
      key_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.empty = rsp_tuser;
         got.code = rsp_tdata[CODE_W-1:0];
         got.mods = rsp_tdata[CODE_W +: MOD_W];
         got.ch = rsp_tdata[CODE_W + MOD_W +: CHAR_W];
         got.ovf = rsp_tdata[RSP_FIELD_W - 1];
         got.pad = rsp_tdata[RSP_TDATA_W - 1 -: RSP_PAD_W];
         if (pending_keys.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word tuser %b tdata %h", $time, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_keys.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch (exp/got) empty %b/%b code %h/%h mods %h/%h ",
                            "char %h/%h ovf %b/%b pad %h/%h"}, $time,
                           want.empty, got.empty, want.code, got.code, want.mods, got.mods,
                           want.ch, got.ch, want.ovf, got.ovf, want.pad, got.pad);
            end
         end
      end
   end

   // Read from an untouched queue: empty flag, all data zero
   task automatic test_empty_read();
      send_word(CMD_READ, '0);
      send_word(CMD_READ, 8'hff);
      wait_drained();
   endtask

   // Modifier make/break tracking, shifted and plain lookups, codes off the table
   task automatic test_decode_basics();
      logic [CODE_W-1:0] script[$];
      script = '{8'h2a, 8'h1e, 8'h36, 8'haa, 8'h0d, 8'hb6, 8'h1d, 8'h38,
                 8'h9d, 8'hb8, 8'h39, 8'h40, 8'h9e, 8'hff, 8'h00};
      foreach (script[i]) send_word(CMD_PUSH, script[i]);
      repeat (script.size() + 1) send_word(CMD_READ, '0);
      wait_drained();
   endtask

   // Fill the ring, drop two more, then read it dry and once past empty
   task automatic test_full_queue();
      logic [CODE_W-1:0] code;
      tx_gaps = 1'b0;
      rx_stalls = 1'b1;
      while (ring_codes.size() < QUEUE_DEPTH) begin
         next_typed_code(code);
         send_word(CMD_PUSH, code);
      end
      send_word(CMD_PUSH, 8'h1e);
      send_word(CMD_PUSH, 8'hff);
      while (ring_codes.size() > 0) send_word(CMD_READ, CODE_W'($urandom_range(0, 255)));
      send_word(CMD_READ, '0);
      wait_drained();
   endtask

   // Bursts of typing with a varying push/read mix so the ring swings full and empty
   task automatic test_random_typing(input int words);
      int                sent;
      int                burst;
      int                push_pct;
      bit                paused;
      logic [CODE_W-1:0] code;
      sent = 0;
      paused = 1'b0;
      while (sent < words) begin
         burst = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0:       push_pct = 25;
            1:       push_pct = 50;
            2:       push_pct = 75;
            default: push_pct = 95;
         endcase
         tx_gaps = $urandom_range(0, 3) != 0;
         rx_stalls = $urandom_range(0, 3) != 0;
         repeat (burst) begin
            if ($urandom_range(0, 99) < push_pct) begin
               next_typed_code(code);
               send_word(CMD_PUSH, code);
            end else begin
               // Read data field is don't care; toggle it anyway
               send_word(CMD_READ, CODE_W'($urandom_range(0, 255)));
            end
            sent++;
         end
         // Hold the sender once midway until every key word is back
         if (!paused && sent >= words / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_read();
      tx_gaps = 1'b1;
      rx_stalls = 1'b1;
      test_decode_basics();
      test_random_typing(1000);
      test_full_queue();
      test_random_typing(1000);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_keys.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/kbdsc_pkg.sv
rtl/kbdsc_ram.sv
rtl/kbdsc_decode.sv
rtl/keyboard_scancode_queue_decoder_unit.sv
verif/keyboard_scancode_queue_decoder_unit_tb.sv
